// ----- rtl/core/dfht_pkg.sv -----
`default_nettype none

package dfht_pkg;

    // temperature word width, 1/16 degree c per lsb
    localparam int TEMP_WIDTH = 12;
    localparam int HYST_WIDTH = TEMP_WIDTH - 1;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [TEMP_WIDTH-1:0] t_temp;
    typedef logic signed [TEMP_WIDTH:0]   t_temp_ext;
    typedef logic        [HYST_WIDTH-1:0] t_hyst;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAN1_THR  = 3'd0,
        CFG_FAN2_THR  = 3'd1,
        CFG_HYST      = 3'd2,
        CFG_FS_BOTH   = 3'd3,
        CFG_FAN1_AUTO = 3'd4,
        CFG_FAN2_AUTO = 3'd5,
        CFG_FAN1_MAN  = 3'd6,
        CFG_FAN2_MAN  = 3'd7
    } t_cfg_idx;

    localparam t_temp FAN1_THR_RST = t_temp'(560);
    localparam t_temp FAN2_THR_RST = t_temp'(640);
    localparam t_hyst HYST_RST     = t_hyst'(32);

    typedef struct packed {
        t_temp fan1_thr;
        t_temp fan2_thr;
        t_hyst hyst;
        logic  fs_both;
        logic  fan1_auto;
        logic  fan2_auto;
        logic  fan1_man;
        logic  fan2_man;
    } t_cfg;

    typedef struct packed {
        t_temp top_mean;
        logic  top_valid;
        logic  top_mismatch;
        t_temp bottom_mean;
        logic  bottom_valid;
        logic  bottom_mismatch;
        logic  any_usable;
    } t_snap;

    typedef struct packed {
        logic  fan1_on;
        logic  fan2_on;
        logic  failsafe_active;
        t_temp control_temp;
        logic  control_temp_valid;
    } t_res;

    // switch on first, then test for switch off in the same step
    function automatic logic auto_fan(logic cur, t_temp temp, t_temp thr, t_hyst hyst);
        t_temp_ext temp_x;
        t_temp_ext off_pt;
        logic      st;
        temp_x = t_temp_ext'(temp);
        off_pt = t_temp_ext'(thr) - t_temp_ext'({1'b0, hyst});
        st     = cur | (temp >= thr);
        return st & ~(temp_x <= off_pt);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dfht_if.sv -----
`default_nettype none

interface dfht_in_if;
    logic              valid;
    logic              ready;
    dfht_pkg::t_temp   top_mean;
    logic              top_valid;
    logic              top_mismatch;
    dfht_pkg::t_temp   bottom_mean;
    logic              bottom_valid;
    logic              bottom_mismatch;
    logic              any_usable;

    modport source(output valid, top_mean, top_valid, top_mismatch, bottom_mean,
                   bottom_valid, bottom_mismatch, any_usable, input ready);
    modport sink(input valid, top_mean, top_valid, top_mismatch, bottom_mean,
                 bottom_valid, bottom_mismatch, any_usable, output ready);
endinterface

interface dfht_out_if;
    logic              valid;
    logic              ready;
    logic              fan1_on;
    logic              fan2_on;
    logic              failsafe_active;
    dfht_pkg::t_temp   control_temp;
    logic              control_temp_valid;

    modport source(output valid, fan1_on, fan2_on, failsafe_active, control_temp,
                   control_temp_valid, input ready);
    modport sink(input valid, fan1_on, fan2_on, failsafe_active, control_temp,
                 control_temp_valid, output ready);
endinterface

interface dfht_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dfht_pkg::CFG_IDX_W-1:0]     index;
    logic [dfht_pkg::TEMP_WIDTH-1:0]    wdata;

    modport source(output valid, index, wdata, input ready);
    modport sink(input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dfht_cfg_regs.sv -----
`default_nettype none

module dfht_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_wr,
    input  wire [dfht_pkg::CFG_IDX_W-1:0]    i_idx,
    input  wire [dfht_pkg::TEMP_WIDTH-1:0]   i_wdata,
    output dfht_pkg::t_cfg                   o_cfg
);

    dfht_pkg::t_cfg     r_cfg;
    dfht_pkg::t_cfg     n_cfg;
    dfht_pkg::t_cfg_idx w_idx;

    assign w_idx = dfht_pkg::t_cfg_idx'(i_idx);

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (w_idx)
                dfht_pkg::CFG_FAN1_THR:  n_cfg.fan1_thr  = dfht_pkg::t_temp'(i_wdata);
                dfht_pkg::CFG_FAN2_THR:  n_cfg.fan2_thr  = dfht_pkg::t_temp'(i_wdata);
                dfht_pkg::CFG_HYST:      n_cfg.hyst      = i_wdata[dfht_pkg::HYST_WIDTH-1:0];
                dfht_pkg::CFG_FS_BOTH:   n_cfg.fs_both   = i_wdata[0];
                dfht_pkg::CFG_FAN1_AUTO: n_cfg.fan1_auto = i_wdata[0];
                dfht_pkg::CFG_FAN2_AUTO: n_cfg.fan2_auto = i_wdata[0];
                dfht_pkg::CFG_FAN1_MAN:  n_cfg.fan1_man  = i_wdata[0];
                dfht_pkg::CFG_FAN2_MAN:  n_cfg.fan2_man  = i_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fan1_thr  <= dfht_pkg::FAN1_THR_RST;
            r_cfg.fan2_thr  <= dfht_pkg::FAN2_THR_RST;
            r_cfg.hyst      <= dfht_pkg::HYST_RST;
            r_cfg.fs_both   <= 1'b1;
            r_cfg.fan1_auto <= 1'b1;
            r_cfg.fan2_auto <= 1'b1;
            r_cfg.fan1_man  <= 1'b0;
            r_cfg.fan2_man  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/dfht_decide.sv -----
`default_nettype none

module dfht_decide (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire dfht_pkg::t_snap i_snap,
    input  wire dfht_pkg::t_cfg  i_cfg,
    output dfht_pkg::t_res      o_res
);

    logic            r_fan1;
    logic            r_fan2;
    logic            n_fan1;
    logic            n_fan2;
    logic            w_fs;
    logic            w_vld;
    dfht_pkg::t_temp w_ctl;

    always_comb begin
        w_fs  = ~i_snap.any_usable | i_snap.top_mismatch | i_snap.bottom_mismatch;
        w_vld = i_snap.top_valid | i_snap.bottom_valid;

        // larger valid mean, or the only valid one, else zero
        if (i_snap.top_valid && i_snap.bottom_valid) begin
            w_ctl = (i_snap.top_mean > i_snap.bottom_mean) ? i_snap.top_mean
                                                           : i_snap.bottom_mean;
        end else if (i_snap.top_valid) begin
            w_ctl = i_snap.top_mean;
        end else if (i_snap.bottom_valid) begin
            w_ctl = i_snap.bottom_mean;
        end else begin
            w_ctl = '0;
        end

        n_fan1 = r_fan1;
        n_fan2 = r_fan2;
        if (w_fs && i_cfg.fs_both) begin
            n_fan1 = 1'b1;
            n_fan2 = 1'b1;
        end else begin
            if (!i_cfg.fan1_auto) begin
                n_fan1 = i_cfg.fan1_man;
            end else if (w_vld) begin
                n_fan1 = dfht_pkg::auto_fan(r_fan1, w_ctl, i_cfg.fan1_thr, i_cfg.hyst);
            end
            if (!i_cfg.fan2_auto) begin
                n_fan2 = i_cfg.fan2_man;
            end else if (w_vld) begin
                n_fan2 = dfht_pkg::auto_fan(r_fan2, w_ctl, i_cfg.fan2_thr, i_cfg.hyst);
            end
        end

        o_res.fan1_on            = n_fan1;
        o_res.fan2_on            = n_fan2;
        o_res.failsafe_active    = w_fs;
        o_res.control_temp       = w_ctl;
        o_res.control_temp_valid = w_vld;
    end

    // fan state moves only when the snapshot is handed to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan1 <= 1'b1;
            r_fan2 <= 1'b1;
        end else if (i_adv) begin
            r_fan1 <= n_fan1;
            r_fan2 <= n_fan2;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dual_fan_hysteresis_thermostat_core.sv -----
`default_nettype none

// two-stage hysteresis thermostat for two fan relays
// i_in: one temperature snapshot per beat (top/bottom mean, valid and
//   mismatch flags, any-usable flag), valid/ready
// o_out: one result beat per snapshot (fan commands, failsafe flag,
//   control temperature and its valid flag), valid/ready
// i_cfg: register write beats (index, data); always ready, index order is
//   fan1 threshold, fan2 threshold, hysteresis, failsafe-both-on,
//   fan1 auto, fan2 auto, fan1 manual, fan2 manual
// path: a snapshot accepted on i_in goes through the input register, then
//   through the decision logic into the result register, which drives o_out
// throughput: one snapshot per cycle; the only loop is the one-bit fan
//   state per fan, updated as the snapshot moves into the result register
// stall: while o_out is held, the result register keeps its beat and the
//   input register can still take one more snapshot before i_in.ready drops
// reset: both fans on, registers back to their defaults, both stages empty
// configuration is meant to be written only while no snapshot is in flight

module dual_fan_hysteresis_thermostat_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dfht_in_if.sink     i_in,
    dfht_out_if.source  o_out,
    dfht_cfg_if.sink    i_cfg
);

    dfht_pkg::t_cfg  w_cfg;
    dfht_pkg::t_snap r_snap;
    logic            r_snap_vld;
    dfht_pkg::t_res  w_res;
    dfht_pkg::t_res  r_res;
    logic            r_res_vld;
    logic            w_adv;
    logic            w_in_acc;

    // config registers, writes always taken
    assign i_cfg.ready = 1'b1;

    dfht_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_wdata (i_cfg.wdata),
        .o_cfg   (w_cfg)
    );

    // snapshot moves on when the result register is empty or being drained
    assign w_adv       = r_snap_vld & (~r_res_vld | o_out.ready);
    assign i_in.ready  = ~r_snap_vld | w_adv;
    assign w_in_acc    = i_in.valid & i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_snap_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_snap.top_mean        <= i_in.top_mean;
            r_snap.top_valid       <= i_in.top_valid;
            r_snap.top_mismatch    <= i_in.top_mismatch;
            r_snap.bottom_mean     <= i_in.bottom_mean;
            r_snap.bottom_valid    <= i_in.bottom_valid;
            r_snap.bottom_mismatch <= i_in.bottom_mismatch;
            r_snap.any_usable      <= i_in.any_usable;
        end
    end

    // control temperature select, failsafe and fan state update
    dfht_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_snap  (r_snap),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_adv) begin
            r_res_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid              = r_res_vld;
    assign o_out.fan1_on            = r_res.fan1_on;
    assign o_out.fan2_on            = r_res.fan2_on;
    assign o_out.failsafe_active    = r_res.failsafe_active;
    assign o_out.control_temp       = r_res.control_temp;
    assign o_out.control_temp_valid = r_res.control_temp_valid;

    // failsafe with force-on set drives both fans on in the next result
    a_fs_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_res.failsafe_active && w_cfg.fs_both
        |=> o_out.valid && o_out.fan1_on && o_out.fan2_on)
        else $error("failsafe force-on not applied");

    // no valid mean means a zero control temperature
    a_ctl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.control_temp_valid |-> o_out.control_temp == '0)
        else $error("control temperature not zero without a valid mean");

    // an empty result register never blocks the input side
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_res_vld |-> i_in.ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ----- tb/dual_fan_hysteresis_thermostat_core_test.sv -----
`default_nettype none

module dual_fan_hysteresis_thermostat_core_test;
    import dfht_pkg::*;

    logic i_clk;
    logic i_rst_n;

    dfht_in_if  in_if ();
    dfht_out_if out_if ();
    dfht_cfg_if cfg_if ();

    dual_fan_hysteresis_thermostat_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // free-running clock, period 10
    always #5 i_clk = ~i_clk;

    // snapshots waiting for the driver, and fan decisions waiting for the monitor
    t_snap snap_q[$];
    t_res  decision_q[$];
    t_snap snap_on_bus;

    // random idling on each side, switched off for one long stretch
    bit src_idle_en;
    bit snk_idle_en;
    int fail_cnt;

    // shadow of the thermostat registers and fan state
    t_temp shd_thr1;
    t_temp shd_thr2;
    t_hyst shd_hyst;
    logic  shd_fs_both;
    logic  shd_auto1;
    logic  shd_auto2;
    logic  shd_man1;
    logic  shd_man2;
    logic  fan1_st;
    logic  fan2_st;

    // one fan in auto mode: switch-on test first, then switch-off test
    // off point is thr - hyst in one extra bit so it cannot wrap
    function automatic logic hyst_fan(logic cur, t_temp temp, t_temp thr);
        logic signed [TEMP_WIDTH:0] temp_w;
        logic signed [TEMP_WIDTH:0] thr_w;
        logic signed [TEMP_WIDTH:0] off_pt;
        logic                       st;
        temp_w = temp;
        thr_w  = thr;
        off_pt = thr_w - $signed({2'b00, shd_hyst});
        st     = cur;
        if (!st && temp_w >= thr_w)
            st = 1'b1;
        if (st && temp_w <= off_pt)
            st = 1'b0;
        return st;
    endfunction

    // works out the result for one snapshot and advances the fan state
    function automatic t_res fan_decision(t_snap s);
        t_res  r;
        t_temp top;
        t_temp bot;
        logic  fs;
        logic  ok;
        t_temp ctl;
        top = s.top_mean;
        bot = s.bottom_mean;
        fs  = !s.any_usable || s.top_mismatch || s.bottom_mismatch;
        ok  = s.top_valid || s.bottom_valid;
        ctl = '0;
        if (s.top_valid && s.bottom_valid)
            ctl = (top > bot) ? top : bot;
        else if (s.top_valid)
            ctl = top;
        else if (s.bottom_valid)
            ctl = bot;

        if (fs && shd_fs_both) begin
            // failsafe forces both relays on
            fan1_st = 1'b1;
            fan2_st = 1'b1;
        end else begin
            // no valid mean: auto fans hold their state
            if (shd_auto1) begin
                if (ok)
                    fan1_st = hyst_fan(fan1_st, ctl, shd_thr1);
            end else begin
                fan1_st = shd_man1;
            end
            if (shd_auto2) begin
                if (ok)
                    fan2_st = hyst_fan(fan2_st, ctl, shd_thr2);
            end else begin
                fan2_st = shd_man2;
            end
        end

        r.fan1_on            = fan1_st;
        r.fan2_on            = fan2_st;
        r.failsafe_active    = fs;
        r.control_temp       = ctl;
        r.control_temp_valid = ok;
        return r;
    endfunction

    // register write as seen by the block: each field masked to its width
    function automatic void shadow_write(t_cfg_idx idx, logic [TEMP_WIDTH-1:0] data);
        case (idx)
            CFG_FAN1_THR:  shd_thr1    = t_temp'(data);
            CFG_FAN2_THR:  shd_thr2    = t_temp'(data);
            CFG_HYST:      shd_hyst    = data[HYST_WIDTH-1:0];
            CFG_FS_BOTH:   shd_fs_both = data[0];
            CFG_FAN1_AUTO: shd_auto1   = data[0];
            CFG_FAN2_AUTO: shd_auto2   = data[0];
            CFG_FAN1_MAN:  shd_man1    = data[0];
            CFG_FAN2_MAN:  shd_man2    = data[0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // snapshot driver: offers the next pending snapshot whenever the bus is
    // free, with random idling, and records the expected decision on acceptance
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : snap_driver
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                decision_q.push_back(fan_decision(snap_on_bus));
            if (!in_if.valid || in_if.ready) begin
                if (snap_q.size() != 0 && !(src_idle_en && $urandom_range(0, 99) < 20)) begin
                    snap_on_bus           <= snap_q[0];
                    in_if.top_mean        <= snap_q[0].top_mean;
                    in_if.top_valid       <= snap_q[0].top_valid;
                    in_if.top_mismatch    <= snap_q[0].top_mismatch;
                    in_if.bottom_mean     <= snap_q[0].bottom_mean;
                    in_if.bottom_valid    <= snap_q[0].bottom_valid;
                    in_if.bottom_mismatch <= snap_q[0].bottom_mismatch;
                    in_if.any_usable      <= snap_q[0].any_usable;
                    in_if.valid           <= 1'b1;
                    void'(snap_q.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: random back-pressure, each beat checked against
    // the oldest expected decision
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (decision_q.size() == 0) begin
                    $error("result beat with no snapshot pending");
                    fail_cnt++;
                end else begin
                    want = decision_q.pop_front();
                    if (out_if.fan1_on !== want.fan1_on) begin
                        $error("fan1_on: expected %0d, got %0d", want.fan1_on, out_if.fan1_on);
                        fail_cnt++;
                    end
                    if (out_if.fan2_on !== want.fan2_on) begin
                        $error("fan2_on: expected %0d, got %0d", want.fan2_on, out_if.fan2_on);
                        fail_cnt++;
                    end
                    if (out_if.failsafe_active !== want.failsafe_active) begin
                        $error("failsafe_active: expected %0d, got %0d",
                               want.failsafe_active, out_if.failsafe_active);
                        fail_cnt++;
                    end
                    if (out_if.control_temp !== want.control_temp) begin
                        $error("control_temp: expected %0d, got %0d",
                               $signed(want.control_temp), $signed(out_if.control_temp));
                        fail_cnt++;
                    end
                    if (out_if.control_temp_valid !== want.control_temp_valid) begin
                        $error("control_temp_valid: expected %0d, got %0d",
                               want.control_temp_valid, out_if.control_temp_valid);
                        fail_cnt++;
                    end
                end
            end
            out_if.ready <= !(snk_idle_en && $urandom_range(0, 99) < 20);
        end
    end

    // one register write beat; the shadow follows once it is taken
    task automatic write_reg(t_cfg_idx idx, logic [TEMP_WIDTH-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= data;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        shadow_write(idx, data);
    endtask

    // hold off until every queued snapshot has been taken and answered
    task automatic wait_drained();
        while (snap_q.size() != 0 || in_if.valid || decision_q.size() != 0)
            @(negedge i_clk);
        // latency margin before touching the registers
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_snap mk_snap(int tm, bit tv, bit tmis, int bm, bit bv, bit bmis,
                                      bit usable);
        t_snap s;
        s.top_mean        = t_temp'(tm);
        s.top_valid       = tv;
        s.top_mismatch    = tmis;
        s.bottom_mean     = t_temp'(bm);
        s.bottom_valid    = bv;
        s.bottom_mismatch = bmis;
        s.any_usable      = usable;
        return s;
    endfunction

    function automatic int clamp_temp(int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    // mostly sane snapshots whose temperature lands around a switching
    // point; the rest is raw noise over every bit
    function automatic t_snap rand_snap();
        t_snap s;
        int    thr;
        int    span;
        int    lo;
        if ($urandom_range(0, 99) < 75) begin
            thr  = $urandom_range(0, 1) ? int'(shd_thr1) : int'(shd_thr2);
            span = int'(shd_hyst) + 16;
            lo   = thr - int'(shd_hyst) - 8;
            s.top_mean        = t_temp'(clamp_temp(lo + int'($urandom_range(0, span))));
            s.bottom_mean     = t_temp'(clamp_temp(lo + int'($urandom_range(0, span))));
            s.top_valid       = $urandom_range(0, 99) < 90;
            s.bottom_valid    = $urandom_range(0, 99) < 85;
            s.top_mismatch    = $urandom_range(0, 99) < 4;
            s.bottom_mismatch = $urandom_range(0, 99) < 4;
            s.any_usable      = $urandom_range(0, 99) < 96;
        end else begin
            s = t_snap'($urandom);
            s.top_mean    = t_temp'($urandom);
            s.bottom_mean = t_temp'($urandom);
        end
        return s;
    endfunction

    // every register gets a fresh value; one-bit registers carry junk above bit 0
    task automatic random_config(bit extreme);
        int pick;
        if (extreme) begin
            pick = $urandom_range(0, 2);
            write_reg(CFG_FAN1_THR, (pick == 0) ? 12'h800 : (pick == 1) ? 12'h7ff : 12'($urandom));
            pick = $urandom_range(0, 2);
            write_reg(CFG_FAN2_THR, (pick == 0) ? 12'h800 : (pick == 1) ? 12'h7ff : 12'($urandom));
            pick = $urandom_range(0, 2);
            write_reg(CFG_HYST, (pick == 0) ? 12'h000 : (pick == 1) ? 12'hfff : 12'($urandom));
        end else begin
            write_reg(CFG_FAN1_THR, 12'($urandom_range(400, 800)));
            write_reg(CFG_FAN2_THR, 12'($urandom_range(400, 800)));
            write_reg(CFG_HYST, {1'($urandom), 11'($urandom_range(0, 64))});
        end
        write_reg(CFG_FS_BOTH,   {11'($urandom), 1'($urandom_range(0, 1))});
        write_reg(CFG_FAN1_AUTO, {11'($urandom), 1'($urandom_range(0, 99) < 80)});
        write_reg(CFG_FAN2_AUTO, {11'($urandom), 1'($urandom_range(0, 99) < 80)});
        write_reg(CFG_FAN1_MAN,  {11'($urandom), 1'($urandom_range(0, 1))});
        write_reg(CFG_FAN2_MAN,  {11'($urandom), 1'($urandom_range(0, 1))});
    endtask

    // ---------------------------------------------------------------
    // sequence: reset, directed snapshots at reset settings, corner
    // settings, manual mode, then random phases with fresh settings
    // ---------------------------------------------------------------
    initial begin : stimulus
        int phase;
        int k;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.top_mean        = '0;
        in_if.top_valid       = 1'b0;
        in_if.top_mismatch    = 1'b0;
        in_if.bottom_mean     = '0;
        in_if.bottom_valid    = 1'b0;
        in_if.bottom_mismatch = 1'b0;
        in_if.any_usable      = 1'b0;
        out_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.wdata          = '0;
        snap_on_bus           = '0;
        src_idle_en           = 1'b1;
        snk_idle_en           = 1'b1;
        fail_cnt              = 0;

        // reset settings of the block, both fans on
        shd_thr1    = FAN1_THR_RST;
        shd_thr2    = FAN2_THR_RST;
        shd_hyst    = HYST_RST;
        shd_fs_both = 1'b1;
        shd_auto1   = 1'b1;
        shd_auto2   = 1'b1;
        shd_man1    = 1'b0;
        shd_man2    = 1'b0;
        fan1_st     = 1'b1;
        fan2_st     = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: extremes, mean selection, switching around 560/528
        snap_q.push_back(mk_snap(2047, 1, 0, -2048, 1, 0, 1));
        snap_q.push_back(mk_snap(-2048, 1, 0, 2047, 1, 0, 1));
        snap_q.push_back(mk_snap(-2048, 1, 0, -2048, 0, 0, 1));
        snap_q.push_back(mk_snap(300, 0, 0, 300, 0, 0, 1));    // no valid mean: hold
        snap_q.push_back(mk_snap(0, 0, 0, 560, 1, 0, 1));      // on exactly at threshold
        snap_q.push_back(mk_snap(529, 1, 0, 100, 1, 0, 1));    // just above off point
        snap_q.push_back(mk_snap(528, 1, 0, 528, 1, 0, 1));    // off point, equal means
        snap_q.push_back(mk_snap(559, 1, 0, 0, 0, 0, 1));      // stays off below threshold
        snap_q.push_back(mk_snap(640, 0, 0, 640, 1, 0, 1));    // fan two on
        snap_q.push_back(mk_snap(608, 1, 0, 0, 0, 0, 1));      // fan two off point
        snap_q.push_back(mk_snap(100, 1, 1, 0, 1, 0, 1));      // top mismatch: both forced on
        snap_q.push_back(mk_snap(100, 1, 0, 0, 1, 1, 1));      // bottom mismatch
        snap_q.push_back(mk_snap(100, 1, 0, 0, 1, 0, 0));      // nothing usable
        snap_q.push_back(mk_snap(-5, 0, 1, -5, 0, 1, 0));      // failsafe and no valid mean
        snap_q.push_back(mk_snap(-1, 1, 0, -2, 1, 0, 1));
        wait_drained();

        // failsafe left to normal rules, widest and narrowest hysteresis
        write_reg(CFG_FS_BOTH, 12'h000);
        write_reg(CFG_FAN1_THR, 12'h800);
        write_reg(CFG_FAN2_THR, 12'h7ff);
        write_reg(CFG_HYST, 12'h000);
        snap_q.push_back(mk_snap(-2048, 1, 0, 0, 0, 0, 1));
        snap_q.push_back(mk_snap(2047, 1, 0, 0, 0, 0, 1));
        snap_q.push_back(mk_snap(2047, 1, 1, 0, 0, 1, 0));
        snap_q.push_back(mk_snap(0, 0, 0, -2048, 1, 0, 0));
        wait_drained();
        write_reg(CFG_HYST, 12'hfff);                           // fan1 off point below the range
        snap_q.push_back(mk_snap(-2048, 1, 0, 0, 0, 0, 1));
        snap_q.push_back(mk_snap(2047, 0, 0, 0, 1, 0, 1));
        snap_q.push_back(mk_snap(-2048, 0, 0, -2048, 1, 0, 1));
        wait_drained();

        // manual mode with junk above bit 0, failsafe forcing back on
        write_reg(CFG_FAN1_AUTO, 12'hffe);
        write_reg(CFG_FAN2_AUTO, 12'h002);
        write_reg(CFG_FAN1_MAN, 12'h001);
        write_reg(CFG_FAN2_MAN, 12'hf00);
        snap_q.push_back(mk_snap(1000, 1, 0, 0, 1, 0, 1));
        snap_q.push_back(mk_snap(-1000, 1, 0, 0, 0, 0, 1));
        wait_drained();
        write_reg(CFG_FS_BOTH, 12'h001);
        wait_drained();
        snap_q.push_back(mk_snap(0, 0, 0, 0, 0, 0, 0));
        snap_q.push_back(mk_snap(0, 0, 0, 0, 0, 0, 1));
        wait_drained();

        // random phases; one of them runs with no idling on either side
        for (phase = 0; phase < 8; phase++) begin
            random_config(phase % 3 == 2);
            src_idle_en = (phase != 4);
            snk_idle_en = (phase != 4);
            for (k = 0; k < 225; k++)
                snap_q.push_back(rand_snap());
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin : watchdog
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- dual_fan_hysteresis_thermostat_core.f -----
rtl/core/dfht_pkg.sv
rtl/core/dfht_if.sv
rtl/core/dfht_cfg_regs.sv
rtl/core/dfht_decide.sv
rtl/core/dual_fan_hysteresis_thermostat_core.sv
tb/dual_fan_hysteresis_thermostat_core_test.sv
